FILE: design/dfilt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the per-bin deep filter.
// No dependencies; every other design file imports this package.
package dfilt_pkg;

  localparam int TAPS        = 5;
  localparam int MAX_BINS    = 512;
  localparam int SAMPLE_BITS = 16;

  localparam int BIN_W  = 9;
  localparam int TAP_W  = 3;
  localparam int NFB_W  = 10;
  localparam int LA_W   = 3;
  localparam int SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SUM_W  = $clog2(2 * TAPS) + 1;

  localparam int MEM_DEPTH = MAX_BINS * TAPS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WORD_W    = 2 * SAMPLE_BITS;
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int ACC_W     = 2 * SAMPLE_BITS + 8;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [NFB_W-1:0] NFB_RESET  = NFB_W'(96);
  localparam logic [LA_W-1:0]  LA_RESET   = LA_W'(2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_FILTERED = 2'd0,
    REG_LOOKAHEAD    = 2'd1,
    REG_CONJUGATE    = 2'd2
  } cfg_reg_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic             last;
    logic             clr;
    logic             hold_sel;
    logic             filt;
    logic             conj;
    logic [BIN_W-1:0] bin;
  } ctl_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    sample_t          re;
    sample_t          im;
    logic             sat;
  } res_t;

endpackage

FILE: design/dfilt_in_if.sv
`timescale 1ns / 1ps
// Input item channel: one tap of one bin per transfer.
// Depends on dfilt_pkg.
interface dfilt_in_if;
  import dfilt_pkg::*;

  logic             valid;
  logic             ready;
  logic             frame_start;
  logic [BIN_W-1:0] bin;
  logic [TAP_W-1:0] tap;
  sample_t          spec_re;
  sample_t          spec_im;
  sample_t          coef_re;
  sample_t          coef_im;

  modport source (output valid, frame_start, bin, tap, spec_re, spec_im, coef_re, coef_im,
                  input ready);
  modport sink   (input valid, frame_start, bin, tap, spec_re, spec_im, coef_re, coef_im,
                  output ready);
endinterface

FILE: design/dfilt_out_if.sv
`timescale 1ns / 1ps
// Result channel: one filtered bin per transfer.
// Depends on dfilt_pkg.
interface dfilt_out_if;
  import dfilt_pkg::*;

  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] out_bin;
  sample_t          out_re;
  sample_t          out_im;
  logic             saturated;

  modport source (output valid, out_bin, out_re, out_im, saturated, input ready);
  modport sink   (input valid, out_bin, out_re, out_im, saturated, output ready);
endinterface

FILE: design/dfilt_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on dfilt_pkg.
interface dfilt_cfg_if;
  import dfilt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/dfilt_hist_mem.sv
`timescale 1ns / 1ps
// Frame history memory: one word {re, im} per bin and ring slot.
// Zero-fill sweep after reset; registered read. Depends on dfilt_pkg.
module dfilt_hist_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [dfilt_pkg::ADDR_W-1:0] waddr,
  input  logic [dfilt_pkg::WORD_W-1:0] wdata,
  input  logic                         re,
  input  logic [dfilt_pkg::ADDR_W-1:0] raddr,
  output logic [dfilt_pkg::WORD_W-1:0] rd_data,
  output logic                         clearing
);
  import dfilt_pkg::*;

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-cycle write to the address being read is forwarded
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rd_data <= wdata;
      end else begin
        rd_data <= mem[raddr];
      end
    end
  end

endmodule

FILE: design/dfilt_mac.sv
`timescale 1ns / 1ps
// Complex multiply, shared accumulator, passthrough hold and round/saturate.
// Two register stages after the history read. Depends on dfilt_pkg.
module dfilt_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  dfilt_pkg::ctl_t              ctl,
  input  logic [dfilt_pkg::WORD_W-1:0] x_word,
  input  dfilt_pkg::sample_t           coef_re,
  input  dfilt_pkg::sample_t           coef_im,
  output logic                         res_valid,
  output dfilt_pkg::res_t              res,
  output logic [1:0]                   pending
);
  import dfilt_pkg::*;

  localparam int RND_BIAS = 1 << (SAMPLE_BITS - 3);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // {clipped, value}
  function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + ACC_W'(RND_BIAS)) >>> (SAMPLE_BITS - 2);
    if (r > SAT_HI) begin
      return {1'b1, SAT_HI[SAMPLE_BITS-1:0]};
    end else if (r < SAT_LO) begin
      return {1'b1, SAT_LO[SAMPLE_BITS-1:0]};
    end
    return {1'b0, r[SAMPLE_BITS-1:0]};
  endfunction

  sample_t x_re, x_im;
  assign x_re = x_word[WORD_W-1:SAMPLE_BITS];
  assign x_im = x_word[SAMPLE_BITS-1:0];

  // product stage
  logic                     s2_valid;
  ctl_t                     s2_ctl;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  sample_t                  s2_x_re, s2_x_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl  <= ctl;
    p_rr    <= x_re * coef_re;
    p_ii    <= x_im * coef_im;
    p_ri    <= x_re * coef_im;
    p_ir    <= x_im * coef_re;
    s2_x_re <= x_re;
    s2_x_im <= x_im;
  end

  // accumulate stage
  logic signed [PROD_W:0]  t_re, t_im;
  logic signed [ACC_W-1:0] acc_re, acc_im, acc_re_next, acc_im_next;
  sample_t                 hold_re, hold_im;
  logic                    s3_valid, s3_filt;
  logic [BIN_W-1:0]        s3_bin;

  always_comb begin
    if (s2_ctl.conj) begin
      t_re = (PROD_W+1)'(p_rr) + (PROD_W+1)'(p_ii);
      t_im = (PROD_W+1)'(p_ir) - (PROD_W+1)'(p_ri);
    end else begin
      t_re = (PROD_W+1)'(p_rr) - (PROD_W+1)'(p_ii);
      t_im = (PROD_W+1)'(p_ri) + (PROD_W+1)'(p_ir);
    end
    acc_re_next = (s2_ctl.clr ? '0 : acc_re) + ACC_W'(t_re);
    acc_im_next = (s2_ctl.clr ? '0 : acc_im) + ACC_W'(t_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re   <= '0;
      acc_im   <= '0;
      hold_re  <= '0;
      hold_im  <= '0;
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && s2_ctl.last;
      if (s2_valid) begin
        acc_re <= acc_re_next;
        acc_im <= acc_im_next;
        if (s2_ctl.hold_sel) begin
          hold_re <= s2_x_re;
          hold_im <= s2_x_im;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_bin  <= s2_ctl.bin;
    s3_filt <= s2_ctl.filt;
  end

  // output: filtered bins round the sum, others emit the held frame
  logic [SAMPLE_BITS:0] rs_re, rs_im;

  always_comb begin
    rs_re     = round_sat(acc_re);
    rs_im     = round_sat(acc_im);
    res_valid = s3_valid;
    res.bin   = s3_bin;
    if (s3_filt) begin
      res.re  = rs_re[SAMPLE_BITS-1:0];
      res.im  = rs_im[SAMPLE_BITS-1:0];
      res.sat = rs_re[SAMPLE_BITS] | rs_im[SAMPLE_BITS];
    end else begin
      res.re  = hold_re;
      res.im  = hold_im;
      res.sat = 1'b0;
    end
  end

  assign pending = 2'(s2_valid && s2_ctl.last) + 2'(s3_valid);

endmodule

FILE: design/dfilt_res_fifo.sv
`timescale 1ns / 1ps
// Result queue between the filter pipeline and the result channel.
// Fill level feeds the input credit check. Depends on dfilt_pkg, dfilt_out_if.
module dfilt_res_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  dfilt_pkg::res_t                  push_data,
  dfilt_out_if.source                      results,
  output logic [dfilt_pkg::FIFO_CNT_W-1:0] level
);
  import dfilt_pkg::*;

  res_t                  q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                  pop;
  res_t                  head;

  assign pop  = results.valid && results.ready;
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  assign results.valid     = (level != '0);
  assign results.out_bin   = head.bin;
  assign results.out_re    = head.re;
  assign results.out_im    = head.im;
  assign results.saturated = head.sat;

endmodule

FILE: design/per_bin_complex_deep_filter.sv
`timescale 1ns / 1ps
// Per-bin complex FIR across spectrogram frames (deep filtering), top level.
// Depends on dfilt_pkg, the channel interfaces, dfilt_hist_mem, dfilt_mac, dfilt_res_fifo.
//
//  channel  dir  handshake     carries
//  items    in   valid/ready   frame_start, bin, tap, spec_re/im, coef_re/im
//  results  out  valid/ready   out_bin, out_re, out_im, saturated
//  cfg      in   valid/ready   index, data (always ready)
//
// One item per cycle is taken while items.ready is high; the pipeline is history read,
// products, accumulate, then the result queue, fed from the accumulate register.
// After rst the history's MEM_DEPTH (2560) words are zero-filled with items.ready low.
// A stalled result side only throttles input once the eight-entry result queue,
// counting results still in flight, is full; the pipeline itself never stalls.
module per_bin_complex_deep_filter (
  input  logic        clk,
  input  logic        rst,
  dfilt_in_if.sink    items,
  dfilt_out_if.source results,
  dfilt_cfg_if.sink   cfg
);
  import dfilt_pkg::*;

  // configuration
  logic [NFB_W-1:0] num_filtered_bins;
  logic [LA_W-1:0]  lookahead;
  logic             conjugate;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_filtered_bins <= NFB_RESET;
      lookahead         <= LA_RESET;
      conjugate         <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_NUM_FILTERED: num_filtered_bins <= cfg.data[NFB_W-1:0];
        REG_LOOKAHEAD:    lookahead         <= cfg.data[LA_W-1:0];
        REG_CONJUGATE:    conjugate         <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // item decode and address generation
  logic                  accept, go, tap_ok, bin_ok, clearing;
  logic [SLOT_W-1:0]     newest_slot, newest_adv, newest_eff, rd_slot;
  logic [SUM_W-1:0]      slot_sum;
  logic [LA_W-1:0]       la;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic                  we;
  ctl_t                  ctl;
  logic [WORD_W-1:0]     rd_data;
  logic [FIFO_CNT_W-1:0] fifo_level, inflight;
  logic [1:0]            pending;

  assign accept = items.valid && items.ready;
  assign tap_ok = 32'(items.tap) < TAPS;
  assign bin_ok = 32'(items.bin) < MAX_BINS;
  assign go     = accept && tap_ok && bin_ok;

  always_comb begin
    newest_adv = (newest_slot == SLOT_W'(TAPS - 1)) ? '0 : newest_slot + 1'b1;
    newest_eff = items.frame_start ? newest_adv : newest_slot;
    // tap k reads frame newest - (TAPS-1-k)
    slot_sum   = SUM_W'(newest_eff) + SUM_W'(items.tap) + SUM_W'(1);
    rd_slot    = (slot_sum >= SUM_W'(TAPS)) ? SLOT_W'(slot_sum - SUM_W'(TAPS))
                                            : SLOT_W'(slot_sum);
    la         = (32'(lookahead) > TAPS - 1) ? LA_W'(TAPS - 1) : lookahead;
    waddr      = ADDR_W'(32'(items.bin) * TAPS + 32'(newest_eff));
    raddr      = ADDR_W'(32'(items.bin) * TAPS + 32'(rd_slot));
    we         = go && (items.tap == '0);

    ctl.last     = 32'(items.tap) == TAPS - 1;
    ctl.clr      = items.tap == '0;
    ctl.hold_sel = 32'(items.tap) == TAPS - 1 - 32'(la);
    ctl.filt     = NFB_W'(items.bin) < num_filtered_bins;
    ctl.conj     = conjugate;
    ctl.bin      = items.bin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot <= '0;
    end else if (accept && items.frame_start) begin
      newest_slot <= newest_adv;
    end
  end

  dfilt_hist_mem u_hist (
    .clk      (clk),
    .rst      (rst),
    .we       (we),
    .waddr    (waddr),
    .wdata    ({items.spec_re, items.spec_im}),
    .re       (go),
    .raddr    (raddr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // read stage: control and coefficients wait for the history word
  logic    s1_valid;
  ctl_t    s1_ctl;
  sample_t s1_coef_re, s1_coef_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl     <= ctl;
    s1_coef_re <= items.coef_re;
    s1_coef_im <= items.coef_im;
  end

  logic res_valid;
  res_t res;

  dfilt_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .ctl       (s1_ctl),
    .x_word    (rd_data),
    .coef_re   (s1_coef_re),
    .coef_im   (s1_coef_im),
    .res_valid (res_valid),
    .res       (res),
    .pending   (pending)
  );

  dfilt_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .results   (results),
    .level     (fifo_level)
  );

  // credit: queue space must cover every result still in flight
  assign inflight    = FIFO_CNT_W'(s1_valid && s1_ctl.last) + FIFO_CNT_W'(pending);
  assign items.ready = !clearing &&
                       ((fifo_level + inflight) < FIFO_CNT_W'(FIFO_DEPTH));

  a_no_items_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !items.ready)
    else $error("item ready during history clear");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    newest_slot <= SLOT_W'(TAPS - 1))
    else $error("newest slot out of ring");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    (fifo_level + inflight) <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overcommitted");

  a_result_after_last_tap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(go && ctl.last, 3))
    else $error("result without a last tap");

endmodule
